// ===== rtl/rgbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbp_pkg
// Shared widths, codes, types and channel compare helpers for the RGB
// sliding-window max/min pooling filter.
// ----------------------------------------------------------------------------
package rgbp_pkg;

    // storage sizes
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 7;
    localparam int LINE_CELLS = MAX_WINDOW - 1;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // field widths
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int W_W   = 11;
    localparam int H_W   = 16;
    localparam int N_W   = 3;
    localparam int ROW_W = H_W + 1;
    localparam int IDX_W = 2;
    localparam int CFG_W = 16;

    // largest look-ahead in rows and columns, and the width of the fill count
    localparam int N_TOP = (1 << N_W) - 1;
    localparam int A_MAX = N_TOP - 1 - N_TOP / 2;
    localparam int T_W   = $clog2(A_MAX * MAX_WIDTH + A_MAX + 1);

    // register reset values
    localparam logic [W_W-1:0] RST_WIDTH  = W_W'(640);
    localparam logic [H_W-1:0] RST_HEIGHT = H_W'(480);
    localparam logic [N_W-1:0] RST_WINDOW = N_W'(5);

    // pooling modes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [IDX_W-1:0]
    {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_MODE   = 2'd3
    } cfg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // line store control shared by all line cells
    typedef struct packed
    {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              hit;
        logic              mode;
    } line_ctrl_t;

    // item entering the vertical stage
    typedef struct packed
    {
        logic                  emit;
        logic                  last;
        logic [ADDR_W-1:0]     col;
        pix_t                  pix;
        logic [MAX_WINDOW-1:0] rmask;
        logic [MAX_WINDOW-1:0] hmask;
    } tok1_t;

    // item entering the horizontal stage
    typedef struct packed
    {
        logic                  emit;
        logic                  last;
        logic [MAX_WINDOW-1:0] hmask;
    } tok2_t;

    // per channel max or min of two pixels
    function automatic pix_t pick(input logic mode, input pix_t a, input pix_t b);
        pix_t            r;
        logic [CH_W-1:0] ca;
        logic [CH_W-1:0] cb;
        r = a;
        for (int c = 0; c < 3; c++)
        begin
            ca = a[c*CH_W +: CH_W];
            cb = b[c*CH_W +: CH_W];
            if ((mode == MODE_MIN) ? (cb < ca) : (cb > ca))
            begin
                r[c*CH_W +: CH_W] = cb;
            end
        end
        return r;
    endfunction

    // neutral start value of a reduction
    function automatic pix_t ident(input logic mode);
        return (mode == MODE_MIN) ? '1 : '0;
    endfunction

    // rows (and columns) the window reaches past its centre
    function automatic logic [N_W-1:0] ahead(input logic [N_W-1:0] n);
        return n - N_W'(1) - (n >> 1);
    endfunction

endpackage

// ===== rtl/rgb_window_max_min_pooling.sv =====
// ----------------------------------------------------------------------------
// rgb_window_max_min_pooling
// Streaming NxN max/min filter for RGB pixels in raster order, no padding.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | opcode, blue_in, green_in, red_in
//  out     | out       | out_valid/out_ready  | blue_out, green_out, red_out,
//          |           |                      | frame_last
//
// One item per cycle unless the output stalls or a drain item is held; a
// result passes the line store read, two cell chains and the output register.
// A drain item is held and reissued per position while the frame has fewer
// pixels than the window look-ahead (small frames only).
// Reset clears the counters and pipeline valids; line stores are not cleared.
// A stalled output freezes the whole pipeline; the input is still taken
// while the output register is empty or being emptied and no drain is held.
// ----------------------------------------------------------------------------
module rgb_window_max_min_pooling (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rgbp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rgbp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [rgbp_pkg::CH_W-1:0]     blue_in,
    input  logic [rgbp_pkg::CH_W-1:0]     green_in,
    input  logic [rgbp_pkg::CH_W-1:0]     red_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgbp_pkg::CH_W-1:0]     blue_out,
    output logic [rgbp_pkg::CH_W-1:0]     green_out,
    output logic [rgbp_pkg::CH_W-1:0]     red_out,
    output logic                          frame_last
);
    import rgbp_pkg::*;

    // configuration registers
    logic [W_W-1:0] image_width_reg;
    logic [H_W-1:0] image_height_reg;
    logic [N_W-1:0] window_size_reg;
    logic           pool_mode_reg;

    // position counters
    logic [ROW_W-1:0]  srow_reg,  srow_next;
    logic [ADDR_W-1:0] scol_reg,  scol_next;
    logic [T_W-1:0]    t_reg,     t_next;
    logic [H_W-1:0]    out_row_reg, out_row_next;
    logic [ADDR_W-1:0] out_col_reg, out_col_next;

    // pipeline
    logic  s1_valid_reg, s2_valid_reg, hit_reg, out_valid_reg;
    tok1_t s1_reg, tok1_next;
    tok2_t s2_reg;
    pix_t  out_pix_reg;
    logic  out_last_reg;

    logic           cfg_fire;
    logic           adv;
    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;
    logic [N_W-1:0] n_eff;
    logic [N_W-1:0] a_val;
    logic [T_W-1:0] lat;
    logic           all_in, pending, emit_ok, is_drain, drain_live, hold_drain;
    logic           slot_go, slot_emit, last_now;
    logic [W_W-1:0] scol_inc, out_col_inc, oca, nw;
    logic [ROW_W-1:0] nx;
    line_ctrl_t     lctrl;
    pix_t           down [LINE_CELLS+1];
    pix_t           vacc [LINE_CELLS+1];
    pix_t           tin  [MAX_WINDOW+1];
    pix_t           hacc [MAX_WINDOW+1];

    // effective frame and window sizes
    always_comb
    begin
        w_eff = (image_width_reg == '0) ? W_W'(1) :
                (image_width_reg > W_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : image_width_reg;
        h_eff = (image_height_reg == '0) ? H_W'(1) : image_height_reg;
        n_eff = (window_size_reg == '0) ? N_W'(1) : window_size_reg;
        a_val = ahead(n_eff);
        lat   = T_W'(a_val) * T_W'(w_eff) + T_W'(a_val);
    end

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign adv       = !out_valid_reg || out_ready;

    // item decode and slot issue
    always_comb
    begin
        all_in      = srow_reg >= {1'b0, h_eff};
        pending     = out_row_reg < h_eff;
        emit_ok     = t_reg >= lat;
        is_drain    = (op_t'(opcode) == OP_DRAIN);
        drain_live  = is_drain && all_in && pending;
        hold_drain  = in_valid && drain_live && !emit_ok;
        in_ready    = adv && !hold_drain;
        slot_go     = adv && in_valid && ((!is_drain && !all_in) || drain_live);
        slot_emit   = slot_go && emit_ok;
        scol_inc    = {1'b0, scol_reg} + W_W'(1);
        out_col_inc = {1'b0, out_col_reg} + W_W'(1);
        last_now    = (out_row_reg == h_eff - H_W'(1)) && (out_col_inc >= w_eff);
    end

    // counter next values
    always_comb
    begin
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        t_next       = t_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (cfg_fire || (slot_emit && last_now))
        begin
            srow_next    = '0;
            scol_next    = '0;
            t_next       = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (slot_go)
        begin
            if (scol_inc >= w_eff)
            begin
                scol_next = '0;
                srow_next = srow_reg + ROW_W'(1);
            end
            else
            begin
                scol_next = scol_inc[ADDR_W-1:0];
            end
            if (!emit_ok)
            begin
                t_next = t_reg + T_W'(1);
            end
            if (slot_emit)
            begin
                if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + H_W'(1);
                end
                else
                begin
                    out_col_next = out_col_inc[ADDR_W-1:0];
                end
            end
        end
    end

    // row and column masks for the new item
    always_comb
    begin
        nx  = {{(ROW_W-N_W){1'b0}}, n_eff};
        nw  = {{(W_W-N_W){1'b0}}, n_eff};
        oca = {1'b0, out_col_reg} + W_W'(a_val);
        tok1_next.emit = emit_ok;
        tok1_next.last = last_now;
        tok1_next.col  = scol_reg;
        tok1_next.pix  = {red_in, green_in, blue_in};
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            tok1_next.rmask[k] = (nx > ROW_W'(k)) && (srow_reg >= ROW_W'(k)) &&
                                 ((srow_reg - ROW_W'(k)) < {1'b0, h_eff});
            tok1_next.hmask[k] = (nw > W_W'(k)) && (oca >= W_W'(k)) &&
                                 ((oca - W_W'(k)) < w_eff);
        end
    end

    // configuration writes and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_WIDTH;
            image_height_reg <= RST_HEIGHT;
            window_size_reg  <= RST_WINDOW;
            pool_mode_reg    <= MODE_MAX;
            srow_reg         <= '0;
            scol_reg         <= '0;
            t_reg            <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:  image_width_reg  <= cfg_data[W_W-1:0];
                    CFG_HEIGHT: image_height_reg <= cfg_data[H_W-1:0];
                    CFG_WINDOW: window_size_reg  <= cfg_data[N_W-1:0];
                    CFG_MODE:   pool_mode_reg    <= cfg_data[0];
                endcase
            end
            srow_reg    <= srow_next;
            scol_reg    <= scol_next;
            t_reg       <= t_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= slot_go;
            hit_reg       <= slot_go && s1_valid_reg && (scol_reg == s1_reg.col);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_reg.emit;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= tok1_next;
            s2_reg.emit  <= s1_reg.emit;
            s2_reg.last  <= s1_reg.last;
            s2_reg.hmask <= s1_reg.hmask;
            out_pix_reg  <= hacc[MAX_WINDOW];
            out_last_reg <= s2_reg.last;
        end
    end

    // line store control
    always_comb
    begin
        lctrl.rd_en   = slot_go;
        lctrl.rd_addr = scol_reg;
        lctrl.wr_en   = adv && s1_valid_reg;
        lctrl.wr_addr = s1_reg.col;
        lctrl.hit     = hit_reg;
        lctrl.mode    = pool_mode_reg;
    end

    // vertical chain: newest row first
    assign down[0] = s1_reg.pix;
    assign vacc[0] = s1_reg.rmask[0] ? s1_reg.pix : ident(pool_mode_reg);

    for (genvar k = 1; k <= LINE_CELLS; k++)
    begin : g_line
        rgbp_line_cell u_cell (
            .clk      (clk),
            .ctrl     (lctrl),
            .row_ok   (s1_reg.rmask[k]),
            .down_in  (down[k-1]),
            .acc_in   (vacc[k-1]),
            .down_out (down[k]),
            .acc_out  (vacc[k])
        );
    end

    // horizontal chain: newest column first
    assign tin[0]  = vacc[LINE_CELLS];
    assign hacc[0] = ident(pool_mode_reg);

    for (genvar j = 0; j < MAX_WINDOW; j++)
    begin : g_tap
        rgbp_tap_cell u_cell (
            .clk     (clk),
            .shift   (adv && s1_valid_reg),
            .mode    (pool_mode_reg),
            .use_tap (s2_reg.hmask[j]),
            .tap_in  (tin[j]),
            .tap_out (tin[j+1]),
            .acc_in  (hacc[j]),
            .acc_out (hacc[j+1])
        );
    end

    // outputs
    assign out_valid  = out_valid_reg;
    assign blue_out   = out_pix_reg[0*CH_W +: CH_W];
    assign green_out  = out_pix_reg[1*CH_W +: CH_W];
    assign red_out    = out_pix_reg[2*CH_W +: CH_W];
    assign frame_last = out_last_reg;

`ifndef ASSERT_OFF
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_emit && last_now) |=> (srow_reg == '0 && out_row_reg == '0 && t_reg == '0))
        else $error("counters not cleared after last item of frame");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= lat)
        else $error("fill count beyond latency");

    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && s2_reg.emit) |=> out_valid_reg)
        else $error("emitting item lost before output register");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> s1_valid_reg)
        else $error("line bypass without item in vertical stage");
`endif

endmodule

// ===== rtl/rgbp_ram.sv =====
// ----------------------------------------------------------------------------
// rgbp_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module rgbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rgbp_line_cell.sv =====
// ----------------------------------------------------------------------------
// rgbp_line_cell
// One line store of the vertical chain: reads the older row at the current
// column, hands it to the next cell and folds it into the column result.
// ----------------------------------------------------------------------------
module rgbp_line_cell (
    input  logic                   clk,
    input  rgbp_pkg::line_ctrl_t   ctrl,
    input  logic                   row_ok,
    input  rgbp_pkg::pix_t         down_in,
    input  rgbp_pkg::pix_t         acc_in,
    output rgbp_pkg::pix_t         down_out,
    output rgbp_pkg::pix_t         acc_out
);
    import rgbp_pkg::*;

    pix_t rd_data;
    pix_t fwd_reg;

    // row store, written with the newer row as the older one is read out
    rgbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (ctrl.wr_addr),
        .wr_data (down_in),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ctrl.rd_addr),
        .rd_data (rd_data)
    );

    // last written word, for back-to-back items on one column
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            fwd_reg <= down_in;
        end
    end

    assign down_out = ctrl.hit ? fwd_reg : rd_data;

    // fold this row in when it lies inside the frame and the window
    assign acc_out = row_ok ? pick(ctrl.mode, acc_in, down_out) : acc_in;

endmodule

// ===== rtl/rgbp_tap_cell.sv =====
// ----------------------------------------------------------------------------
// rgbp_tap_cell
// One tap of the horizontal chain: holds a column result, shifts it on and
// folds it into the window result when its column is in range.
// ----------------------------------------------------------------------------
module rgbp_tap_cell (
    input  logic           clk,
    input  logic           shift,
    input  logic           mode,
    input  logic           use_tap,
    input  rgbp_pkg::pix_t tap_in,
    output rgbp_pkg::pix_t tap_out,
    input  rgbp_pkg::pix_t acc_in,
    output rgbp_pkg::pix_t acc_out
);
    import rgbp_pkg::*;

    pix_t tap_reg;

    // column shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tap_reg <= tap_in;
        end
    end

    assign tap_out = tap_reg;
    assign acc_out = use_tap ? pick(mode, acc_in, tap_reg) : acc_in;

endmodule
